// File: sv/tcw_pkg.sv
// Shared constants and controller/datapath interface types for the text console writer.
package tcw_pkg;

	// Screen geometry
	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;

	// Internal widths
	localparam int CELL_AW = $clog2(CELL_COUNT);
	localparam int COL_W   = $clog2(COLUMNS);
	localparam int ROW_W   = $clog2(ROWS);

	// Port widths, fixed by the interface
	localparam int POS_W  = 11;
	localparam int ADDR_W = 11;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int CELL_W = 16;

	localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [ATTR_W-1:0] RESET_COLOR  = 8'h07;

	localparam logic KIND_PUT  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic latch;       // capture the incoming word
		logic clr_write;   // write reset blank at sweep index
		logic sweep_clr;   // sweep index back to zero
		logic sweep_inc;   // sweep index plus one
		logic advance;     // do the put: write cell, move cursor
		logic rd_sweep;    // read port at sweep + one row
		logic copy_issue;  // queue write of read data at sweep index
		logic fill_write;  // write blank in current color at sweep index
		logic emit;        // load result registers and strobe
	} tcw_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic kind_read;
		logic scroll_need;
		logic copy_last;
		logic sweep_last;
	} tcw_status_t;

endpackage

// File: sv/tcw_ctrl.sv
// Sequencing FSM for the text console writer: clear pass, item execution, scroll sweep.
module tcw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  tcw_pkg::tcw_status_t sts,
	output tcw_pkg::tcw_cmd_t    cmd
);
	import tcw_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_COPY,
		ST_DRAIN,
		ST_FILL,
		ST_RESPOND
	} state_t;

	state_t state_q;
	state_t state_d;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_write = 1'b1;
				cmd.sweep_inc = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.latch = start;
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.kind_read) begin
					state_d = ST_RESPOND;
				end else begin
					cmd.advance   = 1'b1;
					cmd.sweep_clr = 1'b1;
					state_d       = sts.scroll_need ? ST_COPY : ST_RESPOND;
				end
			end
			ST_COPY: begin
				cmd.rd_sweep   = 1'b1;
				cmd.copy_issue = 1'b1;
				cmd.sweep_inc  = 1'b1;
				if (sts.copy_last) begin
					state_d = ST_DRAIN;
				end
			end
			// last copied cell is written here; keeps the write port free for the fill
			ST_DRAIN: begin
				state_d = ST_FILL;
			end
			ST_FILL: begin
				cmd.fill_write = 1'b1;
				cmd.sweep_inc  = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_RESPOND;
				end
			end
			ST_RESPOND: begin
				cmd.emit = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: sv/tcw_dp.sv
// Datapath for the text console writer: cell memory, cursor, color register, result registers.
module tcw_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tcw_pkg::tcw_cmd_t            cmd,
	output tcw_pkg::tcw_status_t         sts,
	input  logic                         kind,
	input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
	input  logic [tcw_pkg::ADDR_W-1:0]   cell_address,
	input  logic                         text_color_we,
	input  logic [tcw_pkg::ATTR_W-1:0]   text_color,
	output logic                         done,
	output logic [tcw_pkg::POS_W-1:0]    cursor_position,
	output logic [tcw_pkg::CELL_W-1:0]   cell_data
);
	import tcw_pkg::*;

	localparam logic [CELL_AW-1:0] COLS_A      = CELL_AW'(COLUMNS);
	localparam logic [CELL_AW-1:0] LAST_BASE   = CELL_AW'((ROWS - 1) * COLUMNS);
	localparam logic [CELL_AW-1:0] COPY_END    = CELL_AW'(CELL_COUNT - COLUMNS - 1);
	localparam logic [CELL_AW-1:0] SWEEP_END   = CELL_AW'(CELL_COUNT - 1);
	localparam logic [CELL_W-1:0]  RESET_BLANK = {RESET_COLOR, BLANK_CHAR};

	// control state
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [CELL_AW-1:0] pos_q;
	logic [ATTR_W-1:0]  color_q;
	logic [CELL_AW-1:0] sweep_q;
	logic               copy_pend_s1;
	logic               done_q;

	// payload
	logic               kind_q;
	logic [CHAR_W-1:0]  char_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [CELL_AW-1:0] copy_addr_s1;
	logic [CELL_W-1:0]  rd_data_q;
	logic [POS_W-1:0]   cursor_position_q;
	logic [CELL_W-1:0]  cell_data_q;
	logic [CELL_W-1:0]  cell_mem_q [CELL_COUNT];

	// next cursor
	logic [COL_W:0]     col_inc;
	logic [ROW_W:0]     row_inc;
	logic [ROW_W:0]     row_w;
	logic [CELL_AW:0]   pos_w;
	logic [COL_W-1:0]   col_n;
	logic [ROW_W-1:0]   row_n;
	logic [CELL_AW-1:0] pos_n;
	logic               scroll;
	logic               addr_ok;

	// memory ports
	logic               mem_we;
	logic [CELL_AW-1:0] mem_wa;
	logic [CELL_W-1:0]  mem_wd;
	logic [CELL_AW-1:0] mem_ra;

	always_comb begin
		col_inc = {1'b0, col_q} + (COL_W+1)'(1);
		row_inc = {1'b0, row_q} + (ROW_W+1)'(1);
		if (char_q == NEWLINE_CHAR) begin
			col_n = '0;
			row_w = row_inc;
			pos_w = {1'b0, pos_q} - (CELL_AW+1)'(col_q) + (CELL_AW+1)'(COLUMNS);
		end else if (col_inc == (COL_W+1)'(COLUMNS)) begin
			col_n = '0;
			row_w = row_inc;
			pos_w = {1'b0, pos_q} + (CELL_AW+1)'(1);
		end else begin
			col_n = col_inc[COL_W-1:0];
			row_w = {1'b0, row_q};
			pos_w = {1'b0, pos_q} + (CELL_AW+1)'(1);
		end
		scroll = (row_w == (ROW_W+1)'(ROWS));
		if (scroll) begin
			row_n = ROW_W'(ROWS - 1);
			pos_n = LAST_BASE;
		end else begin
			row_n = row_w[ROW_W-1:0];
			pos_n = pos_w[CELL_AW-1:0];
		end
	end

	assign addr_ok = (int'(addr_q) < CELL_COUNT);

	assign sts.kind_read   = (kind_q == KIND_READ);
	assign sts.scroll_need = scroll;
	assign sts.copy_last   = (sweep_q == COPY_END);
	assign sts.sweep_last  = (sweep_q == SWEEP_END);

	// one write port; a queued copy write wins, the controller never overlaps the others
	always_comb begin
		mem_we = 1'b1;
		mem_wa = sweep_q;
		mem_wd = RESET_BLANK;
		if (copy_pend_s1) begin
			mem_wa = copy_addr_s1;
			mem_wd = rd_data_q;
		end else if (cmd.clr_write) begin
			mem_wd = RESET_BLANK;
		end else if (cmd.fill_write) begin
			mem_wd = {color_q, BLANK_CHAR};
		end else if (cmd.advance && char_q != NEWLINE_CHAR) begin
			mem_wa = pos_q;
			mem_wd = {color_q, char_q};
		end else begin
			mem_we = 1'b0;
		end
	end

	assign mem_ra = cmd.rd_sweep ? (sweep_q + COLS_A) : CELL_AW'(addr_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cell_mem_q[mem_wa] <= mem_wd;
		end
		rd_data_q <= cell_mem_q[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			pos_q        <= '0;
			color_q      <= RESET_COLOR;
			sweep_q      <= '0;
			copy_pend_s1 <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			if (text_color_we) begin
				color_q <= text_color;
			end
			if (cmd.advance) begin
				col_q <= col_n;
				row_q <= row_n;
				pos_q <= pos_n;
			end
			if (cmd.sweep_clr) begin
				sweep_q <= '0;
			end else if (cmd.sweep_inc) begin
				sweep_q <= sweep_q + CELL_AW'(1);
			end
			copy_pend_s1 <= cmd.copy_issue;
			done_q       <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q <= kind;
			char_q <= char_code;
			addr_q <= cell_address;
		end
		copy_addr_s1 <= sweep_q;
		if (cmd.emit) begin
			cursor_position_q <= POS_W'(pos_q);
			cell_data_q       <= (kind_q == KIND_READ && addr_ok) ? rd_data_q : '0;
		end
	end

	assign done            = done_q;
	assign cursor_position = cursor_position_q;
	assign cell_data       = cell_data_q;

endmodule

// File: sv/text_console_writer.sv
// Text console writer top level: 80x25 cell store with cursor, put/newline/scroll and cell read.
// A word taken with start passes through the EXEC and RESPOND states; done goes high in the
//   same cycle that busy drops, so a plain put or read is finished before the next word is taken.
// A put that scrolls adds a copy pass over 1920 cells, a drain state and a fill pass over 80 cells,
//   all set by the single read port and single write port of the cell memory.
// Reset: cursor to 0, color to 7; then a clearing pass writes all 2000 cells to 0x0720 while
//   busy is high. Color writes are taken at any time. done is a one-cycle strobe.
module text_console_writer (
	input  logic                       clk,
	input  logic                       arst_n,
	// command side
	input  logic                       start,
	output logic                       busy,
	input  logic                       kind,
	input  logic [tcw_pkg::CHAR_W-1:0] char_code,
	input  logic [tcw_pkg::ADDR_W-1:0] cell_address,
	// color register
	input  logic                       text_color_we,
	input  logic [tcw_pkg::ATTR_W-1:0] text_color,
	// result side, cannot be stalled
	output logic                       done,
	output logic [tcw_pkg::POS_W-1:0]  cursor_position,
	output logic [tcw_pkg::CELL_W-1:0] cell_data
);
	import tcw_pkg::*;

	tcw_cmd_t    cmd;
	tcw_status_t sts;

	// FSM: owns busy and all sequencing (clear sweep, exec, scroll copy/fill, respond)
	tcw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	// datapath: memory, cursor arithmetic, color register, result word registers
	tcw_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.kind            (kind),
		.char_code       (char_code),
		.cell_address    (cell_address),
		.text_color_we   (text_color_we),
		.text_color      (text_color),
		.done            (done),
		.cursor_position (cursor_position),
		.cell_data       (cell_data)
	);

endmodule
